/* rtl/core/bmkh_pkg.sv */
// Types and constants shared by the multiply key hash block.
package bmkh_pkg;

    localparam logic [63:0] HASH_SEED = 64'd2166136261;
    localparam logic [63:0] MUL_BLOCK = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MUL_TAIL  = 64'hd6e8feb86659fd93;
    localparam logic [3:0]  WORD_BYTES = 4'd8;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last_word;
    } t_req;

    typedef struct packed {
        logic [31:0] key_digest;
        logic        error_flag;
    } t_rsp;

    typedef struct packed {
        logic [63:0] hash;
        logic [7:0]  len;
        logic        seen;
    } t_state;

    localparam t_state STATE_RESET = '{hash: HASH_SEED, len: 8'd0, seen: 1'b0};

endpackage

/* rtl/core/block_multiply_key_hash.sv */
// Top level of the multiply key hash block.
// Path: input register, running hash loop (one 64-bit constant multiply), result register.
// Throughput: one request per cycle unless a held response waits for i_rsp_ready.
// Full non-final words give no result; the final word or a short non-final word (error) gives one.
// Synchronous active-low reset clears the valid bits and reloads the hash seed.
module block_multiply_key_hash
    import bmkh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    logic   in_valid;
    t_req   in_req;
    logic   take;
    t_state mix_state;
    logic   mix_produce;
    t_rsp   mix_rsp;

    t_state r_state;
    logic   r_rsp_valid;
    logic   n_rsp_valid;
    t_rsp   r_rsp;

    bmkh_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .i_take      (take),
        .o_valid     (in_valid),
        .o_req       (in_req)
    );

    bmkh_mix u_mix (
        .i_req     (in_req),
        .i_state   (r_state),
        .o_state   (mix_state),
        .o_produce (mix_produce),
        .o_rsp     (mix_rsp)
    );

    assign take        = in_valid && (!mix_produce || !r_rsp_valid || i_rsp_ready);
    assign n_rsp_valid = (take && mix_produce) || (r_rsp_valid && !i_rsp_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= n_rsp_valid;
            if (take) begin
                r_state <= mix_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && mix_produce) begin
            r_rsp <= mix_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && r_rsp.error_flag |-> r_rsp.key_digest == 32'd0)
        else $error("error response carries a non-zero hash");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && mix_produce |=> r_state == STATE_RESET)
        else $error("state not restarted after a response");

    a_len_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.seen |-> (r_state.len == 8'd0 && r_state.hash == HASH_SEED))
        else $error("length or hash moved without any bytes");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && !i_rsp_ready |=> r_rsp_valid && $stable(r_rsp))
        else $error("pending response lost or changed");

endmodule

/* rtl/core/bmkh_in_reg.sv */
// Input register stage holding one request ahead of the hash step.
module bmkh_in_reg
    import bmkh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    input  logic i_take,
    output logic o_valid,
    output t_req o_req
);

    logic r_valid;
    logic n_valid;
    t_req r_req;

    assign o_req_ready = !r_valid || i_take;
    assign n_valid     = (i_req_valid && o_req_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

/* rtl/core/bmkh_mix.sv */
// Hash step for one word: tail build, XOR, constant multiply and fold.
module bmkh_mix
    import bmkh_pkg::*;
(
    input  t_req   i_req,
    input  t_state i_state,
    output t_state o_state,
    output logic   o_produce,
    output t_rsp   o_rsp
);

    logic [3:0]  count;
    logic        full;
    logic [7:0]  total;
    logic [63:0] masked;
    logic [63:0] tail;
    logic [63:0] operand;
    logic [63:0] mul_const;
    logic [63:0] lo_lo;
    logic [31:0] hi_lo;
    logic [31:0] lo_hi;
    logic [63:0] product;
    logic        seen_final;

    assign count = (i_req.byte_count > WORD_BYTES) ? WORD_BYTES : i_req.byte_count;
    assign full  = (count == WORD_BYTES);
    assign total = i_state.len + {4'd0, count};

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            masked[8*i +: 8] = (4'(i) < count) ? i_req.data_word[8*i +: 8] : 8'd0;
        end
    end

    assign tail      = {masked[55:0], total};
    assign operand   = i_state.hash ^ (full ? i_req.data_word : tail);
    assign mul_const = full ? MUL_BLOCK : MUL_TAIL;

    assign lo_lo   = operand[31:0] * mul_const[31:0];
    assign hi_lo   = 32'(operand[63:32] * mul_const[31:0]);
    assign lo_hi   = 32'(operand[31:0] * mul_const[63:32]);
    assign product = lo_lo + {hi_lo + lo_hi, 32'd0};

    assign seen_final = i_state.seen || (count != 4'd0);

    always_comb begin
        o_state   = STATE_RESET;
        o_produce = 1'b1;
        o_rsp     = '{key_digest: 32'd0, error_flag: 1'b0};
        if (!i_req.last_word) begin
            if (full) begin
                o_state.hash = product;
                o_state.len  = i_state.len + {4'd0, WORD_BYTES};
                o_state.seen = 1'b1;
                o_produce    = 1'b0;
            end else begin
                o_rsp.error_flag = 1'b1;
            end
        end else if (seen_final) begin
            if (count != 4'd0) begin
                o_rsp.key_digest = product[31:0] ^ product[63:32];
            end else begin
                o_rsp.key_digest = i_state.hash[31:0] ^ i_state.hash[63:32];
            end
        end
    end

endmodule
